// ===== hw/rtl/stereo_peak_rms_meter_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Stereo peak/RMS meter assertion macros
// Concurrent assertion wrappers on clk and rst_n, empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef STEREO_PEAK_RMS_METER_UNIT_MACROS_SVH
`define STEREO_PEAK_RMS_METER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define SPRM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sprm assertion failed");
`define SPRM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sprm assertion failed");
`else
`define SPRM_ASSERT(lbl, prop)
`define SPRM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/sprm_pkg.sv =====
// ----------------------------------------------------------------------------
// Stereo peak/RMS meter package
// Widths, register indexes, reset values and the lane control bundle.
// ----------------------------------------------------------------------------
package sprm_pkg;

    localparam int SAMPLE_BITS_DEF = 24;
    localparam int MAX_FRAMES_DEF  = 4096;

    localparam int SUM_W      = 58;
    localparam int SMOOTH_W   = 47;
    localparam int OUT_W      = 24;
    localparam int ROOT_W     = 24;
    localparam int LEVEL_W    = 23;
    localparam int HOLD_W     = 7;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 23;
    localparam int STEP_W     = $clog2(SUM_W);

    localparam logic [SUM_W-1:0]    SUM_MAX    = '1;
    localparam logic [SMOOTH_W-1:0] SMOOTH_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEVEL = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOUD_LEVEL = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_HOLD  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOUD_HOLD  = 8'd3;

    localparam logic [LEVEL_W-1:0] CLIP_LEVEL_RST = 23'd1048576;
    localparam logic [LEVEL_W-1:0] LOUD_LEVEL_RST = 23'd262144;
    localparam logic [HOLD_W-1:0]  CLIP_HOLD_RST  = 7'd105;
    localparam logic [HOLD_W-1:0]  LOUD_HOLD_RST  = 7'd60;

    typedef struct packed {
        logic mag_load;
        logic sq_load;
        logic acc_load;
        logic div_init;
        logic div_step;
        logic rt_mean;
        logic rt_smooth;
        logic rt_step;
        logic rms_take;
        logic fin;
        logic clear;
    } lane_ctrl_t;

endpackage

// ===== hw/rtl/sprm_intf.sv =====
// ----------------------------------------------------------------------------
// Stereo peak/RMS meter channels
// Frame input, result output and register write channels.
// ----------------------------------------------------------------------------
interface sprm_frame_if #(parameter int SAMPLE_BITS = sprm_pkg::SAMPLE_BITS_DEF);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
    logic                          last_frame;

    modport source (output valid, left_sample, right_sample, last_frame, input ready);
    modport sink   (input valid, left_sample, right_sample, last_frame, output ready);
endinterface

interface sprm_result_if;
    logic                          valid;
    logic                          ready;
    logic [sprm_pkg::OUT_W-1:0]    peak_left;
    logic [sprm_pkg::OUT_W-1:0]    peak_right;
    logic [sprm_pkg::OUT_W-1:0]    rms_left;
    logic [sprm_pkg::OUT_W-1:0]    rms_right;
    logic [sprm_pkg::OUT_W-1:0]    smoothed_rms_left;
    logic [sprm_pkg::OUT_W-1:0]    smoothed_rms_right;
    logic [sprm_pkg::HOLD_W-1:0]   indicator_left;
    logic [sprm_pkg::HOLD_W-1:0]   indicator_right;
    logic                          overflow;

    modport source (output valid, peak_left, peak_right, rms_left, rms_right,
                    smoothed_rms_left, smoothed_rms_right, indicator_left,
                    indicator_right, overflow, input ready);
    modport sink   (input valid, peak_left, peak_right, rms_left, rms_right,
                    smoothed_rms_left, smoothed_rms_right, indicator_left,
                    indicator_right, overflow, output ready);
endinterface

interface sprm_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [sprm_pkg::CFG_IDX_W-1:0]  index;
    logic [sprm_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/stereo_peak_rms_meter_unit.sv =====
// ----------------------------------------------------------------------------
// Stereo peak/RMS meter
// Two channel lanes under one sequencer, merged into one result register.
// ----------------------------------------------------------------------------
//  channel  | role   | moves
//  frame    | sink   | one stereo frame per transaction
//  result   | source | one buffer summary per transaction
//  cfg      | sink   | one register write per transaction, always ready
//
//  A frame passes through the square and accumulate states; the closing frame also
//  runs the restoring divider (one quotient bit per cycle over the 58-bit square
//  sum) and two 24-step square roots in each lane.
//  A finished result waits in the output register while new frames are taken;
//  a closing frame stalls only if the previous result is still not taken.
//  Reset clears accumulators and indicators and sets config registers to defaults.
module stereo_peak_rms_meter_unit #(
    parameter int SAMPLE_BITS = sprm_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_FRAMES  = sprm_pkg::MAX_FRAMES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    sprm_frame_if.sink     frame,
    sprm_result_if.source  result,
    sprm_cfg_if.sink       cfg
);

`include "stereo_peak_rms_meter_unit_macros.svh"

    localparam int CNT_W = $clog2(MAX_FRAMES + 1);

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b000_0000_0001,
        ST_SQ     = 11'b000_0000_0010,
        ST_ACC    = 11'b000_0000_0100,
        ST_DSET   = 11'b000_0000_1000,
        ST_DIV    = 11'b000_0001_0000,
        ST_RSET_M = 11'b000_0010_0000,
        ST_ROOT_M = 11'b000_0100_0000,
        ST_RSET_S = 11'b000_1000_0000,
        ST_ROOT_S = 11'b001_0000_0000,
        ST_FIN    = 11'b010_0000_0000,
        ST_PUSH   = 11'b100_0000_0000
    } state_t;

    state_t                         state_reg, state_next;
    logic [sprm_pkg::STEP_W-1:0]    step_reg, step_next;
    logic [CNT_W-1:0]               count_reg;
    logic                           sat_reg;
    logic                           last_reg;
    logic [sprm_pkg::LEVEL_W-1:0]   clip_level_reg, loud_level_reg;
    logic [sprm_pkg::HOLD_W-1:0]    clip_hold_reg, loud_hold_reg;
    logic                           res_vld_reg;

    logic [sprm_pkg::OUT_W-1:0]     peak_l_reg, peak_r_reg, rms_l_reg, rms_r_reg;
    logic [sprm_pkg::OUT_W-1:0]     srms_l_reg, srms_r_reg;
    logic [sprm_pkg::HOLD_W-1:0]    ind_l_reg, ind_r_reg;
    logic                           ovf_reg;

    sprm_pkg::lane_ctrl_t           ctrl;
    logic                           accept;
    logic                           load;
    logic                           sat_l, sat_r;
    logic [sprm_pkg::OUT_W-1:0]     peak_l, peak_r, rms_l, rms_r, srms_l, srms_r;
    logic [sprm_pkg::HOLD_W-1:0]    hold_l, hold_r;

    assign frame.ready = (state_reg == ST_IDLE);
    assign accept      = frame.valid && frame.ready;
    assign load        = (state_reg == ST_PUSH) && (!res_vld_reg || result.ready);
    assign cfg.ready   = 1'b1;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        ctrl       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ctrl.mag_load = accept;
                if (accept)
                begin
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                ctrl.sq_load = 1'b1;
                state_next   = ST_ACC;
            end
            ST_ACC:
            begin
                ctrl.acc_load = 1'b1;
                state_next    = last_reg ? ST_DSET : ST_IDLE;
            end
            ST_DSET:
            begin
                ctrl.div_init = 1'b1;
                step_next     = '0;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                ctrl.div_step = 1'b1;
                step_next     = step_reg + 1'b1;
                if (step_reg == sprm_pkg::STEP_W'(sprm_pkg::SUM_W - 1))
                begin
                    state_next = ST_RSET_M;
                end
            end
            ST_RSET_M:
            begin
                ctrl.rt_mean = 1'b1;
                step_next    = '0;
                state_next   = ST_ROOT_M;
            end
            ST_ROOT_M:
            begin
                ctrl.rt_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == sprm_pkg::STEP_W'(sprm_pkg::ROOT_W - 1))
                begin
                    state_next = ST_RSET_S;
                end
            end
            ST_RSET_S:
            begin
                ctrl.rms_take  = 1'b1;
                ctrl.rt_smooth = 1'b1;
                step_next      = '0;
                state_next     = ST_ROOT_S;
            end
            ST_ROOT_S:
            begin
                ctrl.rt_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == sprm_pkg::STEP_W'(sprm_pkg::ROOT_W - 1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                ctrl.fin   = 1'b1;
                state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                ctrl.clear = load;
                if (load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            count_reg      <= '0;
            sat_reg        <= 1'b0;
            res_vld_reg    <= 1'b0;
            clip_level_reg <= sprm_pkg::CLIP_LEVEL_RST;
            loud_level_reg <= sprm_pkg::LOUD_LEVEL_RST;
            clip_hold_reg  <= sprm_pkg::CLIP_HOLD_RST;
            loud_hold_reg  <= sprm_pkg::LOUD_HOLD_RST;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (ctrl.clear)
            begin
                count_reg <= '0;
                sat_reg   <= 1'b0;
            end
            else if (ctrl.acc_load)
            begin
                if (count_reg < CNT_W'(MAX_FRAMES))
                begin
                    count_reg <= count_reg + 1'b1;
                    sat_reg   <= sat_reg || sat_l || sat_r;
                end
                else
                begin
                    sat_reg <= 1'b1;
                end
            end
            if (load)
            begin
                res_vld_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_vld_reg <= 1'b0;
            end
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    sprm_pkg::REG_CLIP_LEVEL: clip_level_reg <= cfg.data;
                    sprm_pkg::REG_LOUD_LEVEL: loud_level_reg <= cfg.data;
                    sprm_pkg::REG_CLIP_HOLD:
                        clip_hold_reg <= cfg.data[sprm_pkg::HOLD_W-1:0];
                    sprm_pkg::REG_LOUD_HOLD:
                        loud_hold_reg <= cfg.data[sprm_pkg::HOLD_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            last_reg <= frame.last_frame;
        end
        if (load)
        begin
            peak_l_reg <= peak_l;
            peak_r_reg <= peak_r;
            rms_l_reg  <= rms_l;
            rms_r_reg  <= rms_r;
            srms_l_reg <= srms_l;
            srms_r_reg <= srms_r;
            ind_l_reg  <= hold_l;
            ind_r_reg  <= hold_r;
            ovf_reg    <= sat_reg;
        end
    end

    sprm_lane #(.SAMPLE_BITS(SAMPLE_BITS), .CNT_W(CNT_W)) u_lane_left (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .sample     (frame.left_sample),
        .count      (count_reg),
        .clip_level (clip_level_reg),
        .loud_level (loud_level_reg),
        .clip_hold  (clip_hold_reg),
        .loud_hold  (loud_hold_reg),
        .peak       (peak_l),
        .rms        (rms_l),
        .srms       (srms_l),
        .hold       (hold_l),
        .sat        (sat_l)
    );

    sprm_lane #(.SAMPLE_BITS(SAMPLE_BITS), .CNT_W(CNT_W)) u_lane_right (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .sample     (frame.right_sample),
        .count      (count_reg),
        .clip_level (clip_level_reg),
        .loud_level (loud_level_reg),
        .clip_hold  (clip_hold_reg),
        .loud_hold  (loud_hold_reg),
        .peak       (peak_r),
        .rms        (rms_r),
        .srms       (srms_r),
        .hold       (hold_r),
        .sat        (sat_r)
    );

    assign result.valid              = res_vld_reg;
    assign result.peak_left          = peak_l_reg;
    assign result.peak_right         = peak_r_reg;
    assign result.rms_left           = rms_l_reg;
    assign result.rms_right          = rms_r_reg;
    assign result.smoothed_rms_left  = srms_l_reg;
    assign result.smoothed_rms_right = srms_r_reg;
    assign result.indicator_left     = ind_l_reg;
    assign result.indicator_right    = ind_r_reg;
    assign result.overflow           = ovf_reg;

    `SPRM_ASSERT_NEXT(a_accept_to_square, accept, state_reg == ST_SQ)
    `SPRM_ASSERT_NEXT(a_div_to_root, (state_reg == ST_DIV) && (step_reg == sprm_pkg::STEP_W'(sprm_pkg::SUM_W - 1)), state_reg == ST_RSET_M)
    `SPRM_ASSERT_NEXT(a_push_loads, load, res_vld_reg && (state_reg == ST_IDLE) && (count_reg == '0))
    `SPRM_ASSERT(a_count_bound, count_reg <= CNT_W'(MAX_FRAMES))

endmodule

// ===== hw/rtl/sprm_lane.sv =====
// ----------------------------------------------------------------------------
// Stereo peak/RMS meter channel lane
// Peak and square sum of one channel, mean division, root and indicator.
// ----------------------------------------------------------------------------
module sprm_lane #(
    parameter int SAMPLE_BITS = sprm_pkg::SAMPLE_BITS_DEF,
    parameter int CNT_W       = 13
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  sprm_pkg::lane_ctrl_t           ctrl,
    input  logic signed [SAMPLE_BITS-1:0]  sample,
    input  logic [CNT_W-1:0]               count,
    input  logic [sprm_pkg::LEVEL_W-1:0]   clip_level,
    input  logic [sprm_pkg::LEVEL_W-1:0]   loud_level,
    input  logic [sprm_pkg::HOLD_W-1:0]    clip_hold,
    input  logic [sprm_pkg::HOLD_W-1:0]    loud_hold,
    output logic [sprm_pkg::OUT_W-1:0]     peak,
    output logic [sprm_pkg::OUT_W-1:0]     rms,
    output logic [sprm_pkg::OUT_W-1:0]     srms,
    output logic [sprm_pkg::HOLD_W-1:0]    hold,
    output logic                           sat
);

    localparam int SQ_W  = 2 * SAMPLE_BITS;
    localparam int AW    = ((SQ_W > sprm_pkg::SUM_W) ? SQ_W : sprm_pkg::SUM_W) + 1;
    localparam int PW    = (SAMPLE_BITS > sprm_pkg::OUT_W) ? SAMPLE_BITS : sprm_pkg::OUT_W;
    localparam int REM_W = sprm_pkg::ROOT_W + 3;
    localparam int RAD_W = 2 * sprm_pkg::ROOT_W;
    localparam int SW    = sprm_pkg::SMOOTH_W;

    logic [SAMPLE_BITS-1:0]        mag_reg;
    logic [SQ_W-1:0]               sq_reg;
    logic [SAMPLE_BITS-1:0]        peak_reg, peak_next;
    logic [sprm_pkg::SUM_W-1:0]    sum_reg, sum_next;
    logic [sprm_pkg::SUM_W-1:0]    quo_reg, quo_next;
    logic [CNT_W-1:0]              rem_reg, rem_next;
    logic [SW-1:0]                 smooth_reg, smooth_next;
    logic [sprm_pkg::HOLD_W-1:0]   hold_reg, hold_next;
    logic [RAD_W-1:0]              rad_reg;
    logic [REM_W-1:0]              rrem_reg, rrem_next;
    logic [sprm_pkg::ROOT_W-1:0]   root_reg, root_next;
    logic [sprm_pkg::ROOT_W-1:0]   rms_reg, srms_reg;

    logic [SAMPLE_BITS-1:0] raw;
    logic [SAMPLE_BITS-1:0] mag;
    logic [AW-1:0]          acc_sum;
    logic                   acc_ovf;
    logic [CNT_W:0]         div_shift;
    logic [CNT_W:0]         divisor;
    logic                   div_ge;
    logic [SW-1:0]          mean;
    logic [SW:0]            smooth_sum;
    logic [REM_W-1:0]       rt_shift;
    logic [REM_W-1:0]       rt_trial;
    logic                   rt_ge;
    logic [sprm_pkg::HOLD_W-1:0] hold_sel;
    logic [PW-1:0]          peak_wide;

    assign raw = sample;
    assign mag = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;

    assign acc_sum   = AW'(sum_reg) + AW'(sq_reg);
    assign acc_ovf   = acc_sum > AW'(sprm_pkg::SUM_MAX);
    assign sum_next  = acc_ovf ? sprm_pkg::SUM_MAX : acc_sum[sprm_pkg::SUM_W-1:0];
    assign peak_next = (mag_reg > peak_reg) ? mag_reg : peak_reg;
    assign sat       = ctrl.acc_load && acc_ovf;

    assign divisor   = (count == '0) ? (CNT_W + 1)'(1) : {1'b0, count};
    assign div_shift = {rem_reg, quo_reg[sprm_pkg::SUM_W-1]};
    assign div_ge    = div_shift >= divisor;
    assign rem_next  = div_ge ? CNT_W'(div_shift - divisor) : div_shift[CNT_W-1:0];
    assign quo_next  = {quo_reg[sprm_pkg::SUM_W-2:0], div_ge};

    assign mean        = (quo_reg[sprm_pkg::SUM_W-1:SW] != '0) ? sprm_pkg::SMOOTH_MAX
                                                               : quo_reg[SW-1:0];
    assign smooth_sum  = (SW + 1)'(smooth_reg) + (SW + 1)'(mean);
    assign smooth_next = smooth_sum[SW:1];

    assign rt_shift  = {rrem_reg[REM_W-3:0], rad_reg[RAD_W-1:RAD_W-2]};
    assign rt_trial  = REM_W'({root_reg, 2'b01});
    assign rt_ge     = rt_shift >= rt_trial;
    assign rrem_next = rt_ge ? (rt_shift - rt_trial) : rt_shift;
    assign root_next = {root_reg[sprm_pkg::ROOT_W-2:0], rt_ge};

    always_comb
    begin
        priority if (PW'(peak_reg) > PW'(clip_level))
        begin
            hold_sel = clip_hold;
        end
        else if (root_reg > sprm_pkg::ROOT_W'(loud_level))
        begin
            hold_sel = (hold_reg > loud_hold) ? hold_reg : loud_hold;
        end
        else
        begin
            hold_sel = hold_reg;
        end
        hold_next = (hold_sel != '0) ? (hold_sel - 1'b1) : hold_sel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg   <= '0;
            sum_reg    <= '0;
            smooth_reg <= '0;
            hold_reg   <= '0;
        end
        else
        begin
            if (ctrl.clear)
            begin
                peak_reg <= '0;
                sum_reg  <= '0;
            end
            else if (ctrl.acc_load)
            begin
                peak_reg <= peak_next;
                sum_reg  <= sum_next;
            end
            if (ctrl.rt_mean)
            begin
                smooth_reg <= smooth_next;
            end
            if (ctrl.fin)
            begin
                hold_reg <= hold_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mag_load)
        begin
            mag_reg <= mag;
        end
        if (ctrl.sq_load)
        begin
            sq_reg <= SQ_W'(mag_reg) * SQ_W'(mag_reg);
        end
        if (ctrl.div_init)
        begin
            quo_reg <= sum_reg;
            rem_reg <= '0;
        end
        else if (ctrl.div_step)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
        if (ctrl.rt_mean || ctrl.rt_smooth)
        begin
            rad_reg  <= ctrl.rt_mean ? RAD_W'(mean) : RAD_W'(smooth_reg);
            rrem_reg <= '0;
            root_reg <= '0;
        end
        else if (ctrl.rt_step)
        begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rrem_reg <= rrem_next;
            root_reg <= root_next;
        end
        if (ctrl.rms_take)
        begin
            rms_reg <= root_reg;
        end
        if (ctrl.fin)
        begin
            srms_reg <= root_reg;
        end
    end

    assign peak_wide = PW'(peak_reg);
    assign peak      = peak_wide[sprm_pkg::OUT_W-1:0];
    assign rms       = rms_reg;
    assign srms      = srms_reg;
    assign hold      = hold_reg;

endmodule
